@@ src/kwm_pkg.sv @@
// Package for the k-way sorted merge: sequencer states and result status codes.
package kwm_pkg;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef enum logic [1:0] {
		STATUS_ELEM   = 2'd0,
		STATUS_FINISH = 2'd1,
		STATUS_ERROR  = 2'd2
	} status_t;

endpackage

@@ src/kwm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/k_way_sorted_merge.sv @@
// K-way sorted merge: lane head store, sequencer and a single shared min comparator.
//
// Lanes report their first element (or exhaustion) in order 0..active_lanes-1; each
// beat after that refills the lane named by the last emitted result. A load report
// other than the last gives no result. Any other beat starts a scan in which the
// one comparator walks the stored heads, one per cycle, through the head RAM's
// registered read port, with busy high until the scan is done. The result appears
// in the same cycle that busy falls, strobed by result_valid for one cycle; there
// is no back-pressure, so the receiver must take every result beat. A beat for the
// wrong lane is dropped and answered the next cycle with an error status naming the
// expected lane. A configuration write restarts the merge from the load phase.
module k_way_sorted_merge #(
	parameter int LANES      = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [$clog2(LANES)-1:0]      lane,
	input  logic signed [VALUE_BITS-1:0]  value,
	input  logic                          exhausted,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [$clog2(LANES+1)-1:0]    cfg_data,
	output logic                          result_valid,
	output logic signed [VALUE_BITS-1:0]  merged_value,
	output logic [$clog2(LANES)-1:0]      refill_lane,
	output logic [1:0]                    status,
	output logic                          last
);

	localparam int LANE_W = $clog2(LANES);
	localparam int CNT_W  = $clog2(LANES + 1);

	kwm_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]  active_lanes_q;
	logic [CNT_W-1:0]  lane_cnt;
	logic [LANES-1:0]  head_present_q;
	logic              merging_q;
	logic [LANE_W-1:0] expected_q;

	logic [CNT_W-1:0]  rd_cnt_q;
	logic              cmp_vld_s1;
	logic [LANE_W-1:0] cmp_idx_s1;
	logic              found_q;
	logic [LANE_W-1:0] best_idx_q;
	logic signed [VALUE_BITS-1:0] best_val_q;
	logic signed [VALUE_BITS-1:0] head_rdata;

	logic                          result_valid_q;
	logic signed [VALUE_BITS-1:0]  merged_value_q;
	logic [LANE_W-1:0]             refill_lane_q;
	logic [1:0]                    status_q;
	logic                          last_q;

	logic accept, lane_ok, cfg_wr, more_loads, scan_rd, scan_done, take_head;

	// clamp register: 0 behaves as 1, anything above LANES as LANES
	always_comb begin
		priority if (active_lanes_q == '0) begin
			lane_cnt = CNT_W'(1);
		end else if (active_lanes_q > CNT_W'(LANES)) begin
			lane_cnt = CNT_W'(LANES);
		end else begin
			lane_cnt = active_lanes_q;
		end
	end

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid & cfg_ready;
	assign busy       = (state_q != kwm_pkg::ST_IDLE);
	assign accept     = start & ~busy;
	assign lane_ok    = (lane == expected_q);
	assign more_loads = ~merging_q & ((CNT_W'(expected_q) + CNT_W'(1)) < lane_cnt);
	assign scan_rd    = (state_q == kwm_pkg::ST_SCAN) && (rd_cnt_q < lane_cnt);
	assign scan_done  = (state_q == kwm_pkg::ST_SCAN) && !scan_rd && !cmp_vld_s1;

	// compare stage: present head strictly below the best so far (ties keep lower lane)
	assign take_head = cmp_vld_s1 && head_present_q[cmp_idx_s1] &&
	                   (!found_q || (head_rdata < best_val_q));

	kwm_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (LANES)
	) u_heads (
		.clk   (clk),
		.we    (accept && lane_ok && !exhausted),
		.waddr (lane),
		.wdata (value),
		.raddr (rd_cnt_q[LANE_W-1:0]),
		.rdata (head_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kwm_pkg::ST_IDLE: begin
				if (accept && lane_ok && !more_loads) begin
					state_d = kwm_pkg::ST_SCAN;
				end
			end
			kwm_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = kwm_pkg::ST_IDLE;
				end
			end
			default: state_d = kwm_pkg::ST_IDLE;
		endcase
		if (cfg_wr) begin
			state_d = kwm_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// merge state and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_lanes_q <= CNT_W'(LANES);
			head_present_q <= '0;
			merging_q      <= 1'b0;
			expected_q     <= '0;
			rd_cnt_q       <= '0;
			cmp_vld_s1     <= 1'b0;
			found_q        <= 1'b0;
		end else if (cfg_wr) begin
			active_lanes_q <= cfg_data;
			head_present_q <= '0;
			merging_q      <= 1'b0;
			expected_q     <= '0;
			rd_cnt_q       <= '0;
			cmp_vld_s1     <= 1'b0;
			found_q        <= 1'b0;
		end else if (state_q == kwm_pkg::ST_IDLE) begin
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			if (accept && lane_ok) begin
				head_present_q[lane] <= ~exhausted;
				if (more_loads) begin
					expected_q <= expected_q + LANE_W'(1);
				end
			end
		end else begin
			cmp_vld_s1 <= scan_rd;
			if (scan_rd) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (take_head) begin
				found_q <= 1'b1;
			end
			if (scan_done) begin
				if (found_q) begin
					head_present_q[best_idx_q] <= 1'b0;
					expected_q                 <= best_idx_q;
					merging_q                  <= 1'b1;
				end else begin
					// all lanes drained: finish and fall back to loading
					head_present_q <= '0;
					expected_q     <= '0;
					merging_q      <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_cnt_q[LANE_W-1:0];
		if (take_head) begin
			best_idx_q <= cmp_idx_s1;
			best_val_q <= head_rdata;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (accept && !lane_ok) || scan_done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !lane_ok) begin
			merged_value_q <= '0;
			refill_lane_q  <= expected_q;
			status_q       <= kwm_pkg::STATUS_ERROR;
			last_q         <= 1'b0;
		end else if (scan_done) begin
			if (found_q) begin
				merged_value_q <= best_val_q;
				refill_lane_q  <= best_idx_q;
				status_q       <= kwm_pkg::STATUS_ELEM;
				last_q         <= 1'b0;
			end else begin
				merged_value_q <= '0;
				refill_lane_q  <= '0;
				status_q       <= kwm_pkg::STATUS_FINISH;
				last_q         <= 1'b1;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign merged_value = merged_value_q;
	assign refill_lane  = refill_lane_q;
	assign status       = status_q;
	assign last         = last_q;

	a_wrong_lane_error: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (lane != expected_q) |=>
			result_valid && (status == kwm_pkg::STATUS_ERROR))
		else $error("wrong-lane beat not answered with an error");

	a_emitted_head_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == kwm_pkg::STATUS_ELEM) |->
			!head_present_q[refill_lane])
		else $error("emitted lane still holds a head");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !busy && !merging_q && (expected_q == '0))
		else $error("configuration write did not restart the merge");

	a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == kwm_pkg::ST_SCAN))
		else $error("compare stage active outside a scan");

endmodule
